### rtl/ram_change_candidate_filter_core_macros.svh
// Assertion macros used by the block's property module rccf_chk.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef RAM_CHANGE_CANDIDATE_FILTER_CORE_MACROS_SVH
`define RAM_CHANGE_CANDIDATE_FILTER_CORE_MACROS_SVH

// same-cycle implication
`define RCCF_AST_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rccf property failed");

// next-cycle implication
`define RCCF_AST_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rccf property failed");

`endif

### rtl/rccf_pkg.sv
// Types and constants of the RAM change candidate filter.
// Used by rccf_seq, the top level and the property module.
package rccf_pkg;

  localparam int HEAD_W = 6;
  localparam logic [7:0]  COUNT_CAP = 8'd255;
  localparam logic [1:0]  PULSE_MIN = 2'd2;
  localparam logic [6:0]  LIST_CAP  = 7'd64;
  localparam logic [11:0] TOTAL_CAP = 12'd4095;
  localparam logic [15:0] REACTION_RESET = 16'd30;
  localparam logic [15:0] SETTLE_RESET   = 16'd10;

  typedef enum logic [1:0] {
    CMD_OBSERVE      = 2'd0,
    CMD_MARK_CHANGED = 2'd1,
    CMD_MARK_SAME    = 2'd2,
    CMD_LIST         = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_REACTION = 2'd0,
    REG_SETTLE   = 2'd1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_OBS,
    ST_MK_META,
    ST_MK_TIME,
    ST_MK_WB,
    ST_MK_DONE,
    ST_LS_CHK,
    ST_LS_END
  } state_t;

  typedef struct packed {
    cmd_t        command;
    logic [10:0] address;
    logic [7:0]  byte_value;
    logic        frame_last;
    logic [6:0]  max_count;
    logic        want_pulses;
  } in_req_t;

  typedef struct packed {
    logic        result_kind;
    logic [11:0] held_total;
    logic [11:0] pulse_total;
    logic        found;
    logic [10:0] cand_address;
    logic [7:0]  cand_value;
    logic        cand_is_pulse;
    logic        last;
  } out_res_t;

  typedef struct packed {
    logic [15:0] reaction_frames;
    logic [15:0] settle_frames;
  } cfg_t;

  // per-address state word
  typedef struct packed {
    logic [7:0]        cur;
    logic [7:0]        mk;
    logic [HEAD_W-1:0] head;
    logic [7:0]        count;
    logic              held;
    logic              pulse;
  } meta_t;

  localparam meta_t META_RESET = '{cur: 8'd0, mk: 8'd0, head: '0, count: 8'd0,
                                   held: 1'b1, pulse: 1'b1};

endpackage

### rtl/rccf_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing.
module rccf_ram #(
  parameter int W  = 8,
  parameter int D  = 16,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata_r
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

### rtl/rccf_seq.sv
// Command sequencer: observe read-modify-write, mark and list sweeps.
// Depends on rccf_pkg; drives the state-word RAM and the change-time RAM.
module rccf_seq
  import rccf_pkg::*;
#(
  parameter int RAM_BYTES     = 2048,
  parameter int HISTORY_DEPTH = 8,
  parameter int AW            = 11,
  parameter int TW            = 14
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  in_req_t       in_req,
  input  cfg_t          cfg,
  output logic          out_strobe,
  output out_res_t      out_res,
  output logic          meta_we,
  output logic [AW-1:0] meta_waddr,
  output meta_t         meta_wdata,
  output logic [AW-1:0] meta_raddr,
  input  meta_t         meta_rdata,
  output logic          times_we,
  output logic [TW-1:0] times_waddr,
  output logic [31:0]   times_wdata,
  output logic [TW-1:0] times_raddr,
  input  logic [31:0]   times_rdata
);

  localparam int KW = $clog2(HISTORY_DEPTH + 1);
  localparam int SW = $clog2(2 * HISTORY_DEPTH) + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(RAM_BYTES - 1);

  state_t        state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [KW-1:0] k_r, k_nxt;
  meta_t         meta_r, meta_nxt;
  logic [1:0]    win_r, win_nxt;
  logic          quiet_r, quiet_nxt;
  logic          late_r, late_nxt;
  logic [11:0]   held_cnt_r, held_cnt_nxt;
  logic [11:0]   pulse_cnt_r, pulse_cnt_nxt;
  logic [31:0]   win_from_r, win_from_nxt;
  logic [32:0]   late_from_r, late_from_nxt;
  logic          changed_r, changed_nxt;
  logic [31:0]   fn_r, fn_nxt;
  logic [31:0]   ps_r, ps_nxt;
  logic          ever_r, ever_nxt;
  logic [7:0]    obs_val_r, obs_val_nxt;
  logic          obs_last_r, obs_last_nxt;
  logic          obs_ok_r, obs_ok_nxt;
  logic [6:0]    maxc_r, maxc_nxt;
  logic [6:0]    n_r, n_nxt;
  logic          pulses_r, pulses_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  logic [7:0]    pend_val_r, pend_val_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  out_res_t      out_res_r, out_res_nxt;

  logic          accept;
  logic          t_win, t_late, hot, new_held, new_pulse, flag;
  meta_t         upd;
  logic [SW-1:0] next_head;

  function automatic logic [KW-1:0] known_of(input logic [7:0] cnt);
    known_of = (cnt < 8'(HISTORY_DEPTH)) ? KW'(cnt) : KW'(HISTORY_DEPTH);
  endfunction

  // ring slot of the k-th most recent change
  function automatic logic [TW-1:0] taddr(input logic [AW-1:0] a,
                                          input logic [HEAD_W-1:0] head,
                                          input logic [KW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(head) + SW'(HISTORY_DEPTH - 1) - SW'(k);
    if (s >= SW'(HISTORY_DEPTH)) s = s - SW'(HISTORY_DEPTH);
    taddr = TW'(a) * TW'(HISTORY_DEPTH) + TW'(s);
  endfunction

  assign busy       = (state_r != ST_IDLE) || out_strobe_r;
  assign accept     = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  assign t_win  = times_rdata >= win_from_r;
  assign t_late = {1'b0, times_rdata} >= late_from_r;
  assign hot    = meta_r.count > 8'(HISTORY_DEPTH);
  assign flag   = pulses_r ? meta_rdata.pulse : meta_rdata.held;

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    k_nxt          = k_r;
    meta_nxt       = meta_r;
    win_nxt        = win_r;
    quiet_nxt      = quiet_r;
    late_nxt       = late_r;
    held_cnt_nxt   = held_cnt_r;
    pulse_cnt_nxt  = pulse_cnt_r;
    win_from_nxt   = win_from_r;
    late_from_nxt  = late_from_r;
    changed_nxt    = changed_r;
    fn_nxt         = fn_r;
    ps_nxt         = ps_r;
    ever_nxt       = ever_r;
    obs_val_nxt    = obs_val_r;
    obs_last_nxt   = obs_last_r;
    obs_ok_nxt     = obs_ok_r;
    maxc_nxt       = maxc_r;
    n_nxt          = n_r;
    pulses_nxt     = pulses_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    pend_val_nxt   = pend_val_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = '0;
    meta_we        = 1'b0;
    meta_waddr     = addr_r;
    meta_wdata     = meta_r;
    meta_raddr     = addr_r;
    times_we       = 1'b0;
    times_waddr    = '0;
    times_wdata    = fn_r + 32'd1;
    times_raddr    = '0;
    upd            = meta_rdata;
    next_head      = '0;
    new_held       = 1'b0;
    new_pulse      = 1'b0;

    unique case (state_r)
      ST_CLR: begin
        meta_we    = 1'b1;
        meta_wdata = META_RESET;
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          unique case (in_req.command)
            CMD_OBSERVE: begin
              addr_nxt     = AW'(in_req.address);
              meta_raddr   = AW'(in_req.address);
              obs_val_nxt  = in_req.byte_value;
              obs_last_nxt = in_req.frame_last;
              obs_ok_nxt   = {6'd0, in_req.address} < 17'(RAM_BYTES);
              state_nxt    = ST_OBS;
            end
            CMD_MARK_CHANGED, CMD_MARK_SAME: begin
              addr_nxt       = '0;
              meta_raddr     = '0;
              changed_nxt    = (in_req.command == CMD_MARK_CHANGED);
              win_from_nxt   = (fn_r > 32'(cfg.reaction_frames)) ?
                               fn_r - 32'(cfg.reaction_frames) : 32'd0;
              late_from_nxt  = {1'b0, ps_r} + 33'(cfg.settle_frames);
              held_cnt_nxt   = '0;
              pulse_cnt_nxt  = '0;
              state_nxt      = ST_MK_META;
            end
            CMD_LIST: begin
              addr_nxt   = '0;
              meta_raddr = '0;
              maxc_nxt   = (in_req.max_count > LIST_CAP) ? LIST_CAP : in_req.max_count;
              n_nxt      = '0;
              pend_nxt   = 1'b0;
              pulses_nxt = in_req.want_pulses;
              state_nxt  = (!ever_r || in_req.max_count == 7'd0) ? ST_LS_END : ST_LS_CHK;
            end
          endcase
        end
      end

      ST_OBS: begin
        if (obs_ok_r) begin
          meta_we = 1'b1;
          if (fn_r == 32'd0) begin
            upd.cur = obs_val_r;
            upd.mk  = obs_val_r;
          end else if (meta_rdata.cur != obs_val_r) begin
            times_we    = 1'b1;
            times_waddr = TW'(addr_r) * TW'(HISTORY_DEPTH) + TW'(meta_rdata.head);
            next_head   = SW'(meta_rdata.head) + SW'(1);
            upd.cur     = obs_val_r;
            upd.head    = (next_head == SW'(HISTORY_DEPTH)) ? '0 : HEAD_W'(next_head);
            if (meta_rdata.count != COUNT_CAP) upd.count = meta_rdata.count + 8'd1;
          end
          meta_wdata = upd;
        end
        if (obs_last_r) fn_nxt = fn_r + 32'd1;
        state_nxt = ST_IDLE;
      end

      ST_MK_META: begin
        meta_nxt  = meta_rdata;
        win_nxt   = '0;
        quiet_nxt = 1'b0;
        late_nxt  = 1'b0;
        k_nxt     = '0;
        if (known_of(meta_rdata.count) != '0) begin
          times_raddr = taddr(addr_r, meta_rdata.head, '0);
          state_nxt   = ST_MK_TIME;
        end else begin
          state_nxt = ST_MK_WB;
        end
      end

      ST_MK_TIME: begin
        if (t_late) late_nxt = 1'b1;
        if (t_win) begin
          if (win_r != PULSE_MIN) win_nxt = win_r + 2'd1;
        end else if (t_late) begin
          quiet_nxt = 1'b1;
        end
        if (k_r + KW'(1) < known_of(meta_r.count)) begin
          k_nxt       = k_r + KW'(1);
          times_raddr = taddr(addr_r, meta_r.head, k_r + KW'(1));
        end else begin
          state_nxt = ST_MK_WB;
        end
      end

      ST_MK_WB: begin
        if (changed_r) begin
          new_held  = meta_r.held && !hot && !quiet_r && win_r != 2'd0 &&
                      meta_r.cur != meta_r.mk;
          new_pulse = meta_r.pulse && !hot && !quiet_r && win_r == PULSE_MIN &&
                      meta_r.cur == meta_r.mk;
        end else begin
          new_held  = meta_r.held && !(hot || late_r);
          new_pulse = meta_r.pulse && !(hot || late_r);
        end
        meta_we    = 1'b1;
        meta_wdata = '{cur: meta_r.cur, mk: meta_r.cur, head: '0, count: 8'd0,
                       held: new_held, pulse: new_pulse};
        if (new_held && held_cnt_r != TOTAL_CAP) held_cnt_nxt = held_cnt_r + 12'd1;
        if (new_pulse && pulse_cnt_r != TOTAL_CAP) pulse_cnt_nxt = pulse_cnt_r + 12'd1;
        if (addr_r == LAST_ADDR) begin
          state_nxt = ST_MK_DONE;
        end else begin
          addr_nxt   = addr_r + AW'(1);
          meta_raddr = addr_r + AW'(1);
          state_nxt  = ST_MK_META;
        end
      end

      ST_MK_DONE: begin
        out_strobe_nxt          = 1'b1;
        out_res_nxt.held_total  = held_cnt_r;
        out_res_nxt.pulse_total = pulse_cnt_r;
        out_res_nxt.last        = 1'b1;
        ps_nxt    = fn_r;
        ever_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end

      ST_LS_CHK: begin
        // hold one found entry back so the final one can carry last
        if (flag) begin
          if (pend_r) begin
            out_strobe_nxt            = 1'b1;
            out_res_nxt.result_kind   = 1'b1;
            out_res_nxt.found         = 1'b1;
            out_res_nxt.cand_address  = 11'(pend_addr_r);
            out_res_nxt.cand_value    = pend_val_r;
            out_res_nxt.cand_is_pulse = pulses_r;
          end
          pend_nxt      = 1'b1;
          pend_addr_nxt = addr_r;
          pend_val_nxt  = meta_rdata.cur;
          n_nxt         = n_r + 7'd1;
        end
        if ((flag && n_r + 7'd1 == maxc_r) || addr_r == LAST_ADDR) begin
          state_nxt = ST_LS_END;
        end else begin
          addr_nxt   = addr_r + AW'(1);
          meta_raddr = addr_r + AW'(1);
        end
      end

      ST_LS_END: begin
        out_strobe_nxt            = 1'b1;
        out_res_nxt.result_kind   = 1'b1;
        out_res_nxt.found         = pend_r;
        out_res_nxt.cand_address  = pend_r ? 11'(pend_addr_r) : 11'd0;
        out_res_nxt.cand_value    = pend_r ? pend_val_r : 8'd0;
        out_res_nxt.cand_is_pulse = pulses_r;
        out_res_nxt.last          = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      addr_r       <= '0;
      fn_r         <= '0;
      ps_r         <= '0;
      ever_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      pend_r       <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      fn_r         <= fn_nxt;
      ps_r         <= ps_nxt;
      ever_r       <= ever_nxt;
      out_strobe_r <= out_strobe_nxt;
      pend_r       <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r          <= k_nxt;
    meta_r       <= meta_nxt;
    win_r        <= win_nxt;
    quiet_r      <= quiet_nxt;
    late_r       <= late_nxt;
    held_cnt_r   <= held_cnt_nxt;
    pulse_cnt_r  <= pulse_cnt_nxt;
    win_from_r   <= win_from_nxt;
    late_from_r  <= late_from_nxt;
    changed_r    <= changed_nxt;
    obs_val_r    <= obs_val_nxt;
    obs_last_r   <= obs_last_nxt;
    obs_ok_r     <= obs_ok_nxt;
    maxc_r       <= maxc_nxt;
    n_r          <= n_nxt;
    pulses_r     <= pulses_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pend_val_r   <= pend_val_nxt;
    out_res_r    <= out_res_nxt;
  end

endmodule

### rtl/ram_change_candidate_filter_core.sv
// Channel  | ports                          | handshake
// in       | start, busy, in_req            | taken when start && !busy
// out      | out_strobe, out_res            | one-cycle strobe per result, no stall
// cfg      | cfg_valid, cfg_ready, cfg_*    | written when valid && ready
//
// Observe reads the state word, then writes it back.
// Mark sweeps every address: state-word read, min(count, HISTORY_DEPTH) change
// times read one per cycle from the time RAM, write back; then totals reported.
// List scans one address per cycle to max_count entries or the last address.
// After reset a clearing pass over all RAM_BYTES addresses holds busy high.
// Results cannot be stalled; cfg is always ready.
// Depends on rccf_pkg, rccf_ram and rccf_seq.
module ram_change_candidate_filter_core
  import rccf_pkg::*;
#(
  parameter int RAM_BYTES     = 2048,
  parameter int HISTORY_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_req_t     in_req,
  output logic        out_strobe,
  output out_res_t    out_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
  localparam int TD = RAM_BYTES * HISTORY_DEPTH;
  localparam int TW = (TD > 1) ? $clog2(TD) : 1;

  cfg_t          cfg_r, cfg_nxt;
  logic          meta_we, times_we;
  logic [AW-1:0] meta_waddr, meta_raddr;
  meta_t         meta_wdata, meta_rdata;
  logic [TW-1:0] times_waddr, times_raddr;
  logic [31:0]   times_wdata, times_rdata;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_REACTION: cfg_nxt.reaction_frames = cfg_data;
        REG_SETTLE:   cfg_nxt.settle_frames   = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{reaction_frames: REACTION_RESET, settle_frames: SETTLE_RESET};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rccf_ram #(.W($bits(meta_t)), .D(RAM_BYTES), .AW(AW)) u_meta_ram (
    .clk     (clk),
    .we      (meta_we),
    .waddr   (meta_waddr),
    .wdata   (meta_wdata),
    .raddr   (meta_raddr),
    .rdata_r (meta_rdata)
  );

  rccf_ram #(.W(32), .D(TD), .AW(TW)) u_times_ram (
    .clk     (clk),
    .we      (times_we),
    .waddr   (times_waddr),
    .wdata   (times_wdata),
    .raddr   (times_raddr),
    .rdata_r (times_rdata)
  );

  rccf_seq #(
    .RAM_BYTES     (RAM_BYTES),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .AW            (AW),
    .TW            (TW)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .cfg         (cfg_r),
    .out_strobe  (out_strobe),
    .out_res     (out_res),
    .meta_we     (meta_we),
    .meta_waddr  (meta_waddr),
    .meta_wdata  (meta_wdata),
    .meta_raddr  (meta_raddr),
    .meta_rdata  (meta_rdata),
    .times_we    (times_we),
    .times_waddr (times_waddr),
    .times_wdata (times_wdata),
    .times_raddr (times_raddr),
    .times_rdata (times_rdata)
  );

endmodule

### rtl/rccf_chk.sv
// Port-level properties of ram_change_candidate_filter_core, bound to it below.
// Depends on rccf_pkg and ram_change_candidate_filter_core_macros.svh.
`include "ram_change_candidate_filter_core_macros.svh"

module rccf_chk
  import rccf_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_strobe,
  input out_res_t out_res
);

  `RCCF_AST_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `RCCF_AST_IMP(a_result_in_run, clk, rst_n, out_strobe, busy)
  `RCCF_AST_IMP(a_totals_shape, clk, rst_n, out_strobe && !out_res.result_kind, out_res.last && !out_res.found)
  `RCCF_AST_IMP(a_empty_list_last, clk, rst_n, out_strobe && out_res.result_kind && !out_res.found, out_res.last && out_res.cand_address == 11'd0)

endmodule

bind ram_change_candidate_filter_core rccf_chk u_rccf_chk (.*);

### tb/tb.sv
// Self-checking bench for ram_change_candidate_filter_core: random and directed requests,
// with a built-in model of the per-address change history and the candidate flags.
// Depends on rccf_pkg and the block's RTL.
module tb;
  import rccf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBYTES = 2048;
  localparam int HDEPTH = 8;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct {
    in_req_t req;
    bit      drain_first;
  } pend_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_req_t     in_req = '0;
  logic        out_strobe;
  out_res_t    out_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_REACTION;
  logic [15:0] cfg_data = '0;

  ram_change_candidate_filter_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_res(out_res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model state
  logic [7:0]  cur_val  [NBYTES];
  logic [7:0]  mark_val [NBYTES];
  logic [31:0] chg_time [NBYTES][HDEPTH];
  logic [2:0]  ring_head[NBYTES];
  logic [7:0]  chg_cnt  [NBYTES];
  bit          held_ok  [NBYTES];
  bit          pulse_ok [NBYTES];
  logic [31:0] frames_done, period_from;
  bit          marked_once;
  logic [15:0] win_len, settle_len;

  pend_req_t req_backlog[$];
  out_res_t  expected_res[$];
  int        mismatches = 0;
  int        fails = 0;
  int        gap_left = 0;
  bit        no_gaps = 0;
  int        quiet_cycles = 0;
  bit        timed_out = 0;

  function automatic void reset_model();
    for (int a = 0; a < NBYTES; a++) begin
      cur_val[a] = 0; mark_val[a] = 0; ring_head[a] = 0; chg_cnt[a] = 0;
      held_ok[a] = 1; pulse_ok[a] = 1;
    end
    frames_done = 0; period_from = 0; marked_once = 0;
    win_len = REACTION_RESET; settle_len = SETTLE_RESET;
  endfunction

  function automatic void model_observe(in_req_t r);
    int a;
    a = r.address;
    if (frames_done == 0) begin
      cur_val[a] = r.byte_value;
      mark_val[a] = r.byte_value;
    end else if (cur_val[a] != r.byte_value) begin
      cur_val[a] = r.byte_value;
      chg_time[a][ring_head[a]] = frames_done + 32'd1;
      ring_head[a] = ring_head[a] + 3'd1;
      if (chg_cnt[a] < COUNT_CAP) chg_cnt[a] = chg_cnt[a] + 8'd1;
    end
    if (r.frame_last) frames_done = frames_done + 32'd1;
  endfunction

  function automatic void model_mark(bit changed);
    logic [31:0] win_from, t;
    logic [32:0] late_from;
    int held, pulse, known, in_win, early_hits, late, slot;
    bit hot, ok;
    out_res_t r;
    win_from = (frames_done > win_len) ? frames_done - win_len : 32'd0;
    late_from = {1'b0, period_from} + settle_len;
    held = 0; pulse = 0;
    for (int a = 0; a < NBYTES; a++) begin
      known = (chg_cnt[a] < HDEPTH) ? chg_cnt[a] : HDEPTH;
      hot = chg_cnt[a] > HDEPTH;
      in_win = 0; early_hits = 0; late = 0;
      for (int k = 0; k < known; k++) begin
        slot = (ring_head[a] + HDEPTH - 1 - k) % HDEPTH;
        t = chg_time[a][slot];
        if ({1'b0, t} >= late_from) late++;
        if (t >= win_from) in_win++;
        else if ({1'b0, t} >= late_from) early_hits++;
      end
      if (changed) begin
        ok = !hot && early_hits == 0;
        if (held_ok[a]) held_ok[a] = ok && in_win > 0 && cur_val[a] != mark_val[a];
        if (pulse_ok[a]) pulse_ok[a] = ok && in_win >= PULSE_MIN && cur_val[a] == mark_val[a];
      end else if (hot || late > 0) begin
        held_ok[a] = 0;
        pulse_ok[a] = 0;
      end
      held += held_ok[a];
      pulse += pulse_ok[a];
    end
    for (int a = 0; a < NBYTES; a++) begin
      ring_head[a] = 0; chg_cnt[a] = 0; mark_val[a] = cur_val[a];
    end
    period_from = frames_done;
    marked_once = 1;
    r = '0;
    r.held_total = (held > TOTAL_CAP) ? TOTAL_CAP : held[11:0];
    r.pulse_total = (pulse > TOTAL_CAP) ? TOTAL_CAP : pulse[11:0];
    r.last = 1'b1;
    expected_res = {expected_res, r};
  endfunction

  function automatic void model_list(logic [6:0] mc, bit pulses);
    int maxc, n;
    out_res_t r;
    maxc = (mc > LIST_CAP) ? LIST_CAP : mc;
    n = 0;
    if (marked_once) begin
      for (int a = 0; a < NBYTES && n < maxc; a++) begin
        if (pulses ? pulse_ok[a] : held_ok[a]) begin
          r = '0;
          r.result_kind = 1'b1; r.found = 1'b1; r.cand_address = a[10:0];
          r.cand_value = cur_val[a]; r.cand_is_pulse = pulses;
          expected_res = {expected_res, r};
          n++;
        end
      end
    end
    if (n == 0) begin
      r = '0;
      r.result_kind = 1'b1; r.cand_is_pulse = pulses; r.last = 1'b1;
      expected_res = {expected_res, r};
    end else begin
      expected_res[$].last = 1'b1;
    end
  endfunction

  function automatic void predict(in_req_t r);
    case (r.command)
      CMD_OBSERVE:      model_observe(r);
      CMD_MARK_CHANGED: model_mark(1'b1);
      CMD_MARK_SAME:    model_mark(1'b0);
      default:          model_list(r.max_count, r.want_pulses);
    endcase
  endfunction

  function automatic int pick_gap();
    int p;
    if (no_gaps) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict(in_req);
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (req_backlog.size() > 0 &&
                   !(req_backlog[0].drain_first &&
                     (expected_res.size() > 0 || (start && !busy)))) begin
        in_req <= req_backlog.pop_front().req;
        start <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_res.size() == 0) begin
        fails++;
        if (mismatches < 10) $display("unexpected result %p", out_res);
        mismatches++;
      end else begin
        out_res_t e;
        e = expected_res.pop_front();
        if (out_res !== e) begin
          fails++;
          if (mismatches < 10) $display("mismatch: expected %p actual %p", e, out_res);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic in_req_t mk_req(cmd_t c, int addr, int val, bit fl, int mc, bit wp);
    in_req_t r;
    r.command = c; r.address = addr[10:0]; r.byte_value = val[7:0];
    r.frame_last = fl; r.max_count = mc[6:0]; r.want_pulses = wp;
    return r;
  endfunction

  function automatic void push_req(in_req_t r, bit drain);
    pend_req_t p;
    p.req = r;
    p.drain_first = drain;
    req_backlog = {req_backlog, p};
  endfunction

  function automatic in_req_t rand_req();
    int p, addr, val, mc;
    p = $urandom_range(99);
    addr = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(7);
    case ($urandom_range(3))
      0: val = 0;
      1: val = 255;
      2: val = $urandom_range(1);
      default: val = $urandom_range(255);
    endcase
    mc = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(16, 1);
    if (p < 78) return mk_req(CMD_OBSERVE, addr, val, $urandom_range(99) < 40, mc,
                              1'($urandom_range(1)));
    if (p < 85) return mk_req(CMD_MARK_CHANGED, addr, val, 1'($urandom_range(1)), mc,
                              1'($urandom_range(1)));
    if (p < 89) return mk_req(CMD_MARK_SAME, addr, val, 1'($urandom_range(1)), mc,
                              1'($urandom_range(1)));
    return mk_req(CMD_LIST, addr, val, 1'($urandom_range(1)), mc, 1'($urandom_range(1)));
  endfunction

  task automatic wait_idle();
    do @(posedge clk); while (req_backlog.size() > 0 || expected_res.size() > 0 || start || busy);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == REG_REACTION) win_len = val;
    else settle_len = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) push_req(rand_req(), i == n / 2);
    wait_idle();
  endtask

  initial begin
    reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_reg(REG_REACTION, REACTION_RESET);
    write_reg(REG_SETTLE, SETTLE_RESET);
    // list and mark before any frame
    push_req(mk_req(CMD_LIST, 0, 0, 0, 5, 0), 0);
    push_req(mk_req(CMD_LIST, 0, 0, 0, 0, 1), 0);
    push_req(mk_req(CMD_MARK_SAME, 0, 0, 0, 0, 0), 0);
    // first frame loads both stores
    push_req(mk_req(CMD_OBSERVE, 0, 255, 0, 0, 0), 0);
    push_req(mk_req(CMD_OBSERVE, 1, 7, 0, 0, 0), 0);
    push_req(mk_req(CMD_OBSERVE, 2047, 0, 1, 0, 0), 0);
    push_req(mk_req(CMD_OBSERVE, 0, 0, 1, 0, 0), 0);
    push_req(mk_req(CMD_OBSERVE, 0, 255, 0, 0, 0), 0);
    push_req(mk_req(CMD_OBSERVE, 1, 9, 1, 0, 0), 0);
    push_req(mk_req(CMD_OBSERVE, 2047, 170, 1, 0, 0), 0);
    push_req(mk_req(CMD_MARK_CHANGED, 0, 0, 0, 0, 0), 0);
    push_req(mk_req(CMD_LIST, 0, 0, 0, 127, 0), 0);
    push_req(mk_req(CMD_LIST, 0, 0, 0, 64, 1), 0);
    push_req(mk_req(CMD_LIST, 0, 0, 0, 1, 0), 0);
    push_req(mk_req(CMD_LIST, 0, 0, 0, 0, 0), 0);
    // drive one byte busy past the history depth
    for (int i = 0; i < 10; i++) push_req(mk_req(CMD_OBSERVE, 3, i[0] ? 255 : 0, 1, 0, 0), 0);
    push_req(mk_req(CMD_MARK_SAME, 0, 0, 0, 0, 0), 1);
    push_req(mk_req(CMD_LIST, 0, 0, 0, 64, 1), 0);
    wait_idle();
    random_phase(70);
    no_gaps = 1;
    write_reg(REG_REACTION, 16'd0);
    write_reg(REG_SETTLE, 16'd0);
    random_phase(60);
    no_gaps = 0;
    write_reg(REG_REACTION, 16'hFFFF);
    write_reg(REG_SETTLE, 16'hFFFF);
    random_phase(60);
    write_reg(REG_REACTION, 16'($urandom_range(8, 1)));
    write_reg(REG_SETTLE, 16'($urandom_range(4)));
    random_phase(60);
    write_reg(REG_REACTION, 16'($urandom_range(65535)));
    write_reg(REG_SETTLE, 16'($urandom_range(20)));
    random_phase(40);
    repeat (40) @(posedge clk);
    if (fails == 0 && expected_res.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/rccf_pkg.sv
rtl/rccf_ram.sv
rtl/rccf_seq.sv
rtl/ram_change_candidate_filter_core.sv
rtl/rccf_chk.sv
tb/tb.sv
